// ===== hw/rtl/acba_pkg.sv =====
// ----------------------------------------------------------------------------
// Aligned chunk bump allocator package
// Field widths, op and result status codes, configuration register indexes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package acba_pkg;

  localparam int unsigned WORDS_W  = 25;
  localparam int unsigned OFFS_W   = 24;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned IN_W     = 56;
  localparam int unsigned OUT_W    = 56;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [WORDS_W-1:0]  words_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SHIFT_W-1:0]  shift_t;

  localparam status_t ST_CHUNK    = 3'd0;
  localparam status_t ST_PAD      = 3'd1;
  localparam status_t ST_NOSPACE  = 3'd2;
  localparam status_t ST_INVALID  = 3'd3;
  localparam status_t ST_EXPANDED = 3'd4;
  localparam status_t ST_REFUSED  = 3'd5;

  localparam logic OP_TAKE   = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MED      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;

  localparam shift_t SPEC_RESET     = 5'd7;
  localparam shift_t SMALL_RESET    = 5'd9;
  localparam shift_t MED_RESET      = 5'd13;
  localparam words_t RESERVED_RESET = 25'd1048576;

  localparam logic [5:0] MAX_PAD = 6'd46;

endpackage

`default_nettype wire

// ===== hw/rtl/aligned_chunk_bump_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Aligned chunk bump allocator
// Hands out aligned chunks from the top of one region, with padding chunks in
// front of them, and grows the committed part of the region on request.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in_     | slave     | in_tvalid/in_tready  | tuser op, tdata req/preferred words
//  out_    | master    | out_tvalid/out_tready| tdata status/offset/words, tlast
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A take that fits runs S_ALIGN, S_SPACE, any padding walk and S_FINAL; one
// shared adder walks the padding twice: once to count it, once to emit it.
// A granted expand runs S_EXPA to S_EXPC; a refused one ends in S_EXPB, a take
// without space in S_SPACE, an invalid size in S_ALIGN, too much padding in S_PADA.
// Reset loads the register defaults and clears top and committed size. A stalled
// output holds the sequencer; a new item is taken once the last result is registered.
`default_nettype none

module aligned_chunk_bump_allocator_unit #(
  parameter int unsigned REGION_WORDS_LOG2 = 24
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [24:0] req_words, [49:25] pref_words, zero above.
  input  wire  [acba_pkg::IN_W-1:0]         in_tdata,
  // [0] op.
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [2:0] status, [26:3] chunk_offset, [51:27] chunk_words, zero above.
  output logic [acba_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tlast,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [acba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [acba_pkg::WORDS_W-1:0]      cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALIGN = 4'd1;
  localparam logic [3:0] S_SPACE = 4'd2;
  localparam logic [3:0] S_PADA  = 4'd3;
  localparam logic [3:0] S_PADB  = 4'd4;
  localparam logic [3:0] S_FINAL = 4'd5;
  localparam logic [3:0] S_EXPA  = 4'd6;
  localparam logic [3:0] S_EXPB  = 4'd7;
  localparam logic [3:0] S_EXPC  = 4'd8;

  localparam bit CapOn = (REGION_WORDS_LOG2 < 25);
  localparam acba_pkg::words_t CapWords = CapOn ? (25'd1 << REGION_WORDS_LOG2) : 25'd0;

  logic [3:0]              st_r, st_nxt;
  acba_pkg::words_t        req_r, req_nxt;
  acba_pkg::words_t        pref_r, pref_nxt;
  logic [32:0]             next_r, next_nxt;
  acba_pkg::words_t        c_r, c_nxt;
  acba_pkg::words_t        rem_r, rem_nxt;
  logic [5:0]              k_r, k_nxt;
  logic                    emit_r, emit_nxt;
  acba_pkg::words_t        unc_r, unc_nxt;
  acba_pkg::words_t        commit_r, commit_nxt;
  acba_pkg::words_t        top_r, top_nxt;
  acba_pkg::words_t        comm_r, comm_nxt;
  acba_pkg::shift_t        spec_sh_r, small_sh_r, med_sh_r;
  acba_pkg::words_t        rsv_r;
  logic                    out_valid_r, out_valid_nxt;
  acba_pkg::status_t       out_status_r;
  logic [acba_pkg::OFFS_W-1:0] out_off_r;
  acba_pkg::words_t        out_words_r;
  logic                    out_last_r;

  logic                    in_acc;
  logic                    out_free;
  logic                    ld;
  acba_pkg::status_t       ld_status;
  logic [acba_pkg::OFFS_W-1:0] ld_off;
  acba_pkg::words_t        ld_words;
  logic                    ld_last;

  logic [32:0]             sh_a, sh_b;
  logic                    sh_sub;
  logic [33:0]             sh_res;

  logic [acba_pkg::SIZE_W-1:0] spec_v, small_v, med_v, req32, align_v, align_m1, step_full;
  logic                    size_ok, pad_en, small_al, pclamp;
  acba_pkg::words_t        pstep, res_lim;

  assign in_tready  = (st_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_words_r, out_off_r, out_status_r};
  assign out_free   = !out_valid_r || out_tready;

  assign spec_v   = 32'd1 << spec_sh_r;
  assign small_v  = 32'd1 << small_sh_r;
  assign med_v    = 32'd1 << med_sh_r;
  assign req32    = {7'b0, req_r};
  assign size_ok  = (req32 == spec_v) || (req32 == small_v) || (req32 >= med_v);
  assign pad_en   = (req32 <= med_v) && ((req32 == med_v) || (req32 == small_v));
  assign align_v  = (req32 > med_v) ? spec_v : req32;
  assign align_m1 = align_v - 32'd1;

  assign small_al  = (({7'b0, c_r} & (small_v - 32'd1)) == 32'd0);
  assign step_full = small_al ? small_v : spec_v;
  assign pclamp    = (step_full >= {7'b0, rem_r});
  assign pstep     = pclamp ? rem_r : step_full[acba_pkg::WORDS_W-1:0];

  assign res_lim = (CapOn && (rsv_r > CapWords)) ? CapWords : rsv_r;

  // The one shared adder/subtractor; bit 33 flags a negative difference.
  assign sh_res = {1'b0, sh_a} + (sh_sub ? ~{1'b0, sh_b} : {1'b0, sh_b}) + {33'b0, sh_sub};

  always_comb begin
    st_nxt     = st_r;
    req_nxt    = req_r;
    pref_nxt   = pref_r;
    next_nxt   = next_r;
    c_nxt      = c_r;
    rem_nxt    = rem_r;
    k_nxt      = k_r;
    emit_nxt   = emit_r;
    unc_nxt    = unc_r;
    commit_nxt = commit_r;
    top_nxt    = top_r;
    comm_nxt   = comm_r;
    ld         = 1'b0;
    ld_status  = acba_pkg::ST_CHUNK;
    ld_off     = top_r[acba_pkg::OFFS_W-1:0];
    ld_words   = req_r;
    ld_last    = 1'b1;
    sh_a       = '0;
    sh_b       = '0;
    sh_sub     = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt  = in_tdata[24:0];
          pref_nxt = in_tdata[49:25];
          c_nxt    = top_r;
          st_nxt   = (in_tuser == acba_pkg::OP_EXPAND) ? S_EXPA : S_ALIGN;
        end
      end
      S_ALIGN: begin
        sh_a     = {8'b0, top_r};
        sh_b     = {1'b0, align_m1};
        next_nxt = sh_res[32:0] & ~{1'b0, align_m1};
        if (!size_ok) begin
          ld        = out_free;
          ld_status = acba_pkg::ST_INVALID;
          if (out_free) begin
            st_nxt = S_IDLE;
          end
        end else begin
          st_nxt = S_SPACE;
        end
      end
      S_SPACE: begin
        sh_a = next_r;
        sh_b = {8'b0, req_r};
        if ({9'b0, comm_r} < sh_res) begin
          ld        = out_free;
          ld_status = acba_pkg::ST_NOSPACE;
          if (out_free) begin
            st_nxt = S_IDLE;
          end
        end else if (pad_en && (next_r != {8'b0, c_r})) begin
          k_nxt    = '0;
          emit_nxt = 1'b0;
          st_nxt   = S_PADA;
        end else begin
          st_nxt = S_FINAL;
        end
      end
      S_PADA: begin
        sh_a   = next_r;
        sh_b   = {8'b0, c_r};
        sh_sub = 1'b1;
        if (!emit_r && (k_r == acba_pkg::MAX_PAD)) begin
          ld        = out_free;
          ld_status = acba_pkg::ST_INVALID;
          if (out_free) begin
            st_nxt = S_IDLE;
          end
        end else begin
          rem_nxt = sh_res[24:0];
          st_nxt  = S_PADB;
        end
      end
      S_PADB: begin
        sh_a = {8'b0, c_r};
        sh_b = {8'b0, pstep};
        if (!emit_r || out_free) begin
          ld        = emit_r;
          ld_status = acba_pkg::ST_PAD;
          ld_off    = c_r[acba_pkg::OFFS_W-1:0];
          ld_words  = pstep;
          ld_last   = 1'b0;
          c_nxt     = sh_res[24:0];
          k_nxt     = k_r + 6'd1;
          st_nxt    = S_PADA;
          if (pclamp) begin
            if (emit_r) begin
              st_nxt = S_FINAL;
            end else begin
              emit_nxt = 1'b1;
              k_nxt    = '0;
              c_nxt    = top_r;
            end
          end
        end
      end
      S_FINAL: begin
        sh_a = {8'b0, c_r};
        sh_b = {8'b0, req_r};
        if (out_free) begin
          ld        = 1'b1;
          ld_status = acba_pkg::ST_CHUNK;
          ld_off    = c_r[acba_pkg::OFFS_W-1:0];
          top_nxt   = sh_res[24:0];
          st_nxt    = S_IDLE;
        end
      end
      S_EXPA: begin
        sh_a    = {8'b0, res_lim};
        sh_b    = {8'b0, comm_r};
        sh_sub  = 1'b1;
        unc_nxt = sh_res[33] ? '0 : sh_res[24:0];
        st_nxt  = S_EXPB;
      end
      S_EXPB: begin
        if (unc_r < req_r) begin
          ld        = out_free;
          ld_status = acba_pkg::ST_REFUSED;
          ld_off    = comm_r[acba_pkg::OFFS_W-1:0];
          ld_words  = '0;
          if (out_free) begin
            st_nxt = S_IDLE;
          end
        end else begin
          commit_nxt = (pref_r < unc_r) ? pref_r : unc_r;
          st_nxt     = S_EXPC;
        end
      end
      S_EXPC: begin
        sh_a = {8'b0, comm_r};
        sh_b = {8'b0, commit_r};
        if (out_free) begin
          ld        = 1'b1;
          ld_status = acba_pkg::ST_EXPANDED;
          ld_off    = comm_r[acba_pkg::OFFS_W-1:0];
          ld_words  = commit_r;
          comm_nxt  = sh_res[24:0];
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      top_r       <= '0;
      comm_r      <= '0;
      k_r         <= '0;
      emit_r      <= 1'b0;
      spec_sh_r   <= acba_pkg::SPEC_RESET;
      small_sh_r  <= acba_pkg::SMALL_RESET;
      med_sh_r    <= acba_pkg::MED_RESET;
      rsv_r       <= acba_pkg::RESERVED_RESET;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
      comm_r      <= comm_nxt;
      k_r         <= k_nxt;
      emit_r      <= emit_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          acba_pkg::CFG_SPEC:     spec_sh_r  <= cfg_data[acba_pkg::SHIFT_W-1:0];
          acba_pkg::CFG_SMALL:    small_sh_r <= cfg_data[acba_pkg::SHIFT_W-1:0];
          acba_pkg::CFG_MED:      med_sh_r   <= cfg_data[acba_pkg::SHIFT_W-1:0];
          acba_pkg::CFG_RESERVED: rsv_r      <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    pref_r   <= pref_nxt;
    next_r   <= next_nxt;
    c_r      <= c_nxt;
    rem_r    <= rem_nxt;
    unc_r    <= unc_nxt;
    commit_r <= commit_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_off_r    <= ld_off;
      out_words_r  <= ld_words;
      out_last_r   <= ld_last;
    end
  end

  a_comm_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (comm_r >= $past(comm_r)))
    else $error("Committed size decreased.");

  a_cursor_below_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_PADA) || (st_r == S_PADB)) |-> ({8'b0, c_r} < next_r))
    else $error("Padding cursor reached the alignment boundary inside the walk.");

  a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= acba_pkg::MAX_PAD)
    else $error("Padding count exceeded its limit.");

  a_pad_source: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && (ld_status == acba_pkg::ST_PAD)) |-> ((st_r == S_PADB) && emit_r))
    else $error("Padding item issued outside the emit pass.");

  a_top_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_FINAL) |=> $stable(top_r))
    else $error("Top offset moved without a chunk being handed out.");

endmodule

`default_nettype wire

// ===== bench/aligned_chunk_bump_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// Aligned chunk bump allocator checker
// Watches the register, request and result channels. It keeps its own copy of
// the allocator state and predicts the result items of every accepted request.
// Each result item is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module aligned_chunk_bump_allocator_checker
  import acba_pkg::*;
#(
  parameter int unsigned REGION_LOG2 = 24
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  // [24:0] req_words, [49:25] pref_words, zero above.
  input  wire  [IN_W-1:0]       in_tdata,
  // [0] op.
  input  wire                   in_tuser,
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  // [2:0] status, [26:3] chunk_offset, [51:27] chunk_words, zero above.
  input  wire  [OUT_W-1:0]      out_tdata,
  input  wire                   out_tlast,
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [WORDS_W-1:0]    cfg_data,
  output int unsigned           errors,
  output int unsigned           pending,
  output int unsigned           results_seen,
  output int unsigned           pads_seen
);

  typedef struct {
    status_t           status;
    logic [OFFS_W-1:0] offset;
    words_t            words;
    logic              last;
  } alloc_result_t;

  alloc_result_t awaited[$];

  shift_t spec_log2;
  shift_t small_log2;
  shift_t med_log2;
  words_t reserve_words;
  words_t alloc_top;
  words_t committed_total;

  function automatic alloc_result_t make_result(status_t st, logic [63:0] offs,
                                                logic [63:0] words, logic last);
    alloc_result_t r;
    r.status = st;
    r.offset = offs[OFFS_W-1:0];
    r.words  = words[WORDS_W-1:0];
    r.last   = last;
    return r;
  endfunction

  task automatic predict_allocation(logic op, words_t req, words_t pref);
    logic [63:0] reserve;
    logic [63:0] uncommitted;
    logic [63:0] grant;
    logic [63:0] spec_w;
    logic [63:0] small_w;
    logic [63:0] med_w;
    logic [63:0] align;
    logic [63:0] pos;
    logic [63:0] boundary;
    logic [63:0] need;
    logic [63:0] step;
    alloc_result_t pads[$];
    bit too_many;
    if (op == OP_EXPAND) begin
      reserve = 64'd1 << REGION_LOG2;
      if (64'(reserve_words) < reserve) begin
        reserve = 64'(reserve_words);
      end
      uncommitted = (reserve > 64'(committed_total)) ? reserve - 64'(committed_total) : 64'd0;
      if (uncommitted < 64'(req)) begin
        awaited.push_back(make_result(ST_REFUSED, 64'(committed_total), 64'd0, 1'b1));
      end else begin
        grant = (64'(pref) < uncommitted) ? 64'(pref) : uncommitted;
        awaited.push_back(make_result(ST_EXPANDED, 64'(committed_total), grant, 1'b1));
        committed_total = committed_total + grant[WORDS_W-1:0];
      end
    end else begin
      spec_w  = 64'd1 << spec_log2;
      small_w = 64'd1 << small_log2;
      med_w   = 64'd1 << med_log2;
      if (!(64'(req) == spec_w || 64'(req) == small_w || 64'(req) >= med_w)) begin
        awaited.push_back(make_result(ST_INVALID, 64'(alloc_top), 64'(req), 1'b1));
      end else begin
        align    = (64'(req) > med_w) ? spec_w : 64'(req);
        pos      = 64'(alloc_top);
        boundary = (pos + align - 64'd1) & ~(align - 64'd1);
        need     = boundary - pos + 64'(req);
        if (64'(committed_total) < pos || 64'(committed_total) - pos < need) begin
          awaited.push_back(make_result(ST_NOSPACE, 64'(alloc_top), 64'(req), 1'b1));
        end else begin
          too_many = 1'b0;
          // Only small and medium chunks get padding chunks in front of their boundary.
          if (64'(req) <= med_w && (64'(req) == med_w || 64'(req) == small_w)) begin
            while (pos < boundary && !too_many) begin
              step = ((pos & (small_w - 64'd1)) == 64'd0) ? small_w : spec_w;
              if (step > boundary - pos) begin
                step = boundary - pos;
              end
              if (pads.size() >= MAX_PAD) begin
                too_many = 1'b1;
              end else begin
                pads.push_back(make_result(ST_PAD, pos, step, 1'b0));
                pos = pos + step;
              end
            end
          end
          if (too_many) begin
            awaited.push_back(make_result(ST_INVALID, 64'(alloc_top), 64'(req), 1'b1));
          end else begin
            foreach (pads[i]) begin
              awaited.push_back(pads[i]);
            end
            awaited.push_back(make_result(ST_CHUNK, pos, 64'(req), 1'b1));
            pos = pos + 64'(req);
            alloc_top = pos[WORDS_W-1:0];
          end
        end
      end
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t got;
    alloc_result_t want;
    if (!rst_n) begin
      spec_log2       = SPEC_RESET;
      small_log2      = SMALL_RESET;
      med_log2        = MED_RESET;
      reserve_words   = RESERVED_RESET;
      alloc_top       = '0;
      committed_total = '0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEC: begin
            spec_log2 = cfg_data[SHIFT_W-1:0];
          end
          CFG_SMALL: begin
            small_log2 = cfg_data[SHIFT_W-1:0];
          end
          CFG_MED: begin
            med_log2 = cfg_data[SHIFT_W-1:0];
          end
          CFG_RESERVED: begin
            reserve_words = cfg_data;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.status = out_tdata[STATUS_W-1:0];
        got.offset = out_tdata[STATUS_W +: OFFS_W];
        got.words  = out_tdata[STATUS_W+OFFS_W +: WORDS_W];
        got.last   = out_tlast;
        if (got.status == ST_PAD) begin
          pads_seen++;
        end
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected, expected nothing, actual %s",
                   $time, "status/offset/words/last below");
          $display("%0t: actual status %0d offset %0d words %0d last %0d",
                   $time, got.status, got.offset, got.words, got.last);
        end else begin
          want = awaited.pop_front();
          compare_field("status", 64'(want.status), 64'(got.status));
          compare_field("chunk_offset", 64'(want.offset), 64'(got.offset));
          compare_field("chunk_words", 64'(want.words), 64'(got.words));
          compare_field("last", 64'(want.last), 64'(got.last));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_allocation(in_tuser, in_tdata[0 +: WORDS_W], in_tdata[WORDS_W +: WORDS_W]);
      end
    end
    pending = awaited.size();
  end

endmodule

// ===== bench/aligned_chunk_bump_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Aligned chunk bump allocator testbench
// Applies directed and random take and expand requests under several register
// settings and flow-control mixes, including a long output hold. The checker
// beside the block predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module aligned_chunk_bump_allocator_unit_tb;
  import acba_pkg::*;

  localparam int unsigned REGION_LOG2      = 24;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned RANDOM_PER_PHASE = 25;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam logic [63:0] WORDS_MAX        = 64'h1FF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  words_t               cfg_data = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned pads_seen;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_granted = 0;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_applied = 0;

  shift_t cur_spec;
  shift_t cur_small;
  shift_t cur_med;

  always #5 clk = ~clk;

  aligned_chunk_bump_allocator_unit #(
    .REGION_WORDS_LOG2(REGION_LOG2)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  aligned_chunk_bump_allocator_checker #(
    .REGION_LOG2(REGION_LOG2)
  ) result_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending),
    .results_seen(results_seen),
    .pads_seen(pads_seen)
  );

  // The receiver either stalls at random or, when asked, holds off for a
  // long stretch that it counts itself.
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_granted != holds_asked) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_granted++;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, words_t value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(shift_t spec_sh, shift_t small_sh, shift_t med_sh,
                              words_t reserve);
    wait_idle();
    write_reg(CFG_SPEC, words_t'(spec_sh));
    write_reg(CFG_SMALL, words_t'(small_sh));
    write_reg(CFG_MED, words_t'(med_sh));
    write_reg(CFG_RESERVED, reserve);
    cfg_valid = 1'b0;
    cur_spec  = spec_sh;
    cur_small = small_sh;
    cur_med   = med_sh;
    settings_applied++;
  endtask

  task automatic send_request(logic op, words_t req, words_t pref);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {{(IN_W - 2 * WORDS_W){1'b0}}, pref, req};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // Mostly well-formed takes of the configured sizes and expands scaled to
  // them, with some noise that spans every bit of both word fields.
  task automatic send_random_request();
    logic [63:0] spec_w;
    logic [63:0] small_w;
    logic [63:0] med_w;
    logic [63:0] cap;
    logic [63:0] size;
    logic [63:0] pref;
    int unsigned pick;
    logic op;
    spec_w  = 64'd1 << cur_spec;
    small_w = 64'd1 << cur_small;
    med_w   = 64'd1 << cur_med;
    cap     = (4 * med_w > WORDS_MAX) ? WORDS_MAX : 4 * med_w;
    pick    = $urandom_range(99);
    op      = OP_TAKE;
    pref    = 64'($urandom);
    if (pick < 25) begin
      op   = OP_EXPAND;
      size = ($urandom_range(4) == 0) ? 64'($urandom) : 64'($urandom_range(small_w));
      if ($urandom_range(99) < 85) begin
        pref = 64'($urandom_range(cap));
      end
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0: size = spec_w;
        1: size = small_w;
        2: size = med_w;
        default: size = med_w + 64'($urandom_range(med_w, 1));
      endcase
    end else if ($urandom_range(1) == 0) begin
      size = 64'($urandom);
    end else begin
      size = 64'($urandom_range(2 * med_w));
    end
    send_request(op, words_t'(size), words_t'(pref));
  endtask

  initial begin : stimulus
    int unsigned phase;
    shift_t sp;
    shift_t sm;
    shift_t md;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    apply_config(SPEC_RESET, SMALL_RESET, MED_RESET, RESERVED_RESET);

    // Nothing is committed yet, so even valid takes find no space.
    send_request(OP_TAKE, 25'd128, '0);
    send_request(OP_TAKE, 25'd0, '0);
    send_request(OP_TAKE, 25'd100, '0);
    send_request(OP_TAKE, 25'h100_0000, '0);
    send_request(OP_EXPAND, 25'h100_0000, '0);
    send_request(OP_EXPAND, 25'd0, 25'd0);
    send_request(OP_EXPAND, 25'd16, 25'd65536);
    send_request(OP_TAKE, 25'd128, '0);
    send_request(OP_TAKE, 25'd512, '0);
    send_request(OP_TAKE, 25'd128, '0);
    send_request(OP_TAKE, 25'd8192, '0);
    send_request(OP_TAKE, 25'd8193, '0);
    // Unaligned specialized and humongous chunks, then padding cut short.
    send_request(OP_TAKE, 25'd128, '0);
    send_request(OP_TAKE, 25'd10000, '0);
    send_request(OP_TAKE, 25'd512, '0);
    send_request(OP_EXPAND, 25'h10_0000, '0);
    repeat (4) send_request(OP_TAKE, 25'd8192, 25'h1FF_FFFF);
    send_request(OP_EXPAND, 25'd0, 25'h1FF_FFFF);

    for (phase = 0; phase < PHASES; phase++) begin
      sp = shift_t'($urandom_range(8));
      sm = shift_t'(32'(sp) + $urandom_range(4));
      md = shift_t'(32'(sm) + $urandom_range(5));
      case (phase)
        1: apply_config(5'd0, 5'd4, 5'd9, 25'd4096);
        2: apply_config(5'd0, 5'd6, 5'd11, 25'h100_0000);
        3: apply_config(5'd4, 5'd2, 5'd3, 25'h80_0000);
        4: apply_config(5'd0, 5'd0, 5'd0, 25'd0);
        5: apply_config(sp, sm, md, 25'h100_0000);
        6: apply_config(sp, sm, md, words_t'($urandom_range(32'h100_0000)));
        7: apply_config(5'd16, 5'd20, 5'd23, 25'h100_0000);
        default: ;
      endcase
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      if (phase == 5) begin
        // Hold the output while requests keep coming, so the block backs up.
        holds_asked++;
        repeat (12) send_request(OP_TAKE, words_t'(64'd1 << cur_spec), words_t'($urandom));
        wait_idle();
      end
      case (phase % 4)
        1: send_idle_pct = 63;
        2: recv_stall_pct = 63;
        3: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
        default: ;
      endcase
      repeat (RANDOM_PER_PHASE) send_random_request();
    end

    wait_idle();
    $display("Sent %0d requests under %0d register settings; checked %0d result items,",
             requests_sent, settings_applied, results_seen);
    $display("%0d of them padding, with free-running, gapped, stalled and held-off flow.",
             pads_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
